@@ hdl/dcls_pkg.sv @@
`default_nettype none
package dcls_pkg;

    // field widths of one result item
    localparam int COUNT_W = 8;
    localparam int EXP_W   = 5;

    // register index of the limit register (paddr[2])
    localparam logic IDX_LIMIT = 1'b0;

    // reset value of the limit register
    localparam logic [15:0] LIMIT_RESET = 16'hFFFF;

    // store values for primes, for 0 and 1, and the saturated count
    localparam logic [COUNT_W-1:0] D_ONE   = 8'd1;
    localparam logic [COUNT_W-1:0] D_PRIME = 8'd2;
    localparam logic [COUNT_W-1:0] D_SAT   = 8'hFF;
    localparam logic [EXP_W-1:0]   E_ONE   = 5'd1;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_I_RD,
        S_I_CHK,
        S_J_RD,
        S_J_CHK,
        S_Q_RD,
        S_Q_RES
    } dcls_state_t;

    // one result item, packed as it appears in tdata from the highest bit down
    typedef struct packed {
        logic               in_range;
        logic               is_prime;
        logic [EXP_W-1:0]   exponent;
        logic [COUNT_W-1:0] count;
    } dcls_res_t;

endpackage
`default_nettype wire

@@ hdl/divisor_count_linear_sieve.sv @@
// divisor count by linear sieve
//
// the slave stream takes one query item (tdata: query_number); the master
// stream returns one result item per query with d(k), the exponent of the
// smallest prime of k, a prime flag and an in-range flag. the apb port holds
// the limit register at byte address 0; writing it forces a rebuild.
// the first query after reset or after a limit write builds the stores:
// a clearing pass over entries 0..top (top = limit saturated at MAX_N-1),
// then per number 2..top an entry read and check, then a list read and a
// mark per listed prime tried against it, one more read when the list runs
// out first; each composite is marked once through the one entry memory
// write port, with p*i and the count update on separate multipliers. a query
// on built stores reads its entry (S_Q_RD), then loads the output (S_Q_RES).
// s_tready is high only while the sequencer is idle; one item is worked on
// at a time. a result waits in the output register while m_tready is low,
// and the next query may be accepted meanwhile; it then holds in its last
// step until the register frees up.
// reset clears the limit to 65535, the output valid and the built flag, so
// the next query always builds first.
`default_nettype none
module divisor_count_linear_sieve #(
    parameter int MAX_N       = 65536,
    parameter int PRIME_SLOTS = 6542
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // query_number[15:0]
    input  wire logic [15:0] s_tdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // divisor_count[7:0], min_prime_exponent[12:8], is_prime[13], in_range[14]
    output logic [15:0]      m_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    import dcls_pkg::*;

    logic [15:0] limit_reg, limit_next;
    logic        cfg_wr;
    logic        out_valid_reg, out_valid_next;
    dcls_res_t   out_reg, out_next;
    dcls_res_t   res;
    logic        res_valid, res_ready;

    // config port
    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite && (paddr[2] == IDX_LIMIT);
    assign limit_next = cfg_wr ? pwdata[15:0] : limit_reg;
    assign prdata     = (paddr[2] == IDX_LIMIT) ? {16'd0, limit_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // output register
    assign res_ready = !out_valid_reg || m_tready;
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (res_valid && res_ready)
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

    dcls_core #(.MAX_N(MAX_N), .PRIME_SLOTS(PRIME_SLOTS)) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .limit     (limit_reg),
        .rebuild   (cfg_wr),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .query     (s_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule
`default_nettype wire

@@ hdl/dcls_ram.sv @@
`default_nettype none
module dcls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ hdl/dcls_core.sv @@
`default_nettype none
module dcls_core #(
    parameter int MAX_N       = 65536,
    parameter int PRIME_SLOTS = 6542
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [15:0]       limit,
    input  wire logic              rebuild,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [15:0]       query,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output dcls_pkg::dcls_res_t    res
);

    import dcls_pkg::*;

    localparam int NB  = $clog2(MAX_N);
    localparam int TW  = (NB > 16) ? NB : 16;
    localparam int PAW = $clog2(PRIME_SLOTS);
    localparam int PCW = $clog2(PRIME_SLOTS + 1);
    // entry layout from the lowest bit: base, count, exponent, mark, smallest prime
    localparam int B_LO = 0;
    localparam int D_LO = B_LO + COUNT_W;
    localparam int E_LO = D_LO + COUNT_W;
    localparam int M_BIT = E_LO + EXP_W;
    localparam int S_LO = M_BIT + 1;
    localparam int EW   = S_LO + NB;

    dcls_state_t state_reg, state_next;
    logic [15:0]        k_reg, k_next;
    logic               built_reg, built_next;
    logic [NB-1:0]      cnt_reg, cnt_next;
    logic [NB:0]        i_reg, i_next;
    logic [PCW-1:0]     j_reg, j_next;
    logic [PCW-1:0]     pc_reg, pc_next;
    logic [COUNT_W-1:0] d_i_reg, d_i_next;
    logic [COUNT_W-1:0] b_i_reg, b_i_next;
    logic [EXP_W-1:0]   e_i_reg, e_i_next;
    logic [NB-1:0]      s_i_reg, s_i_next;

    logic          e_we;
    logic [NB-1:0] e_waddr, e_raddr;
    logic [EW-1:0] e_wdata, e_rdata;
    logic           p_we;
    logic [PAW-1:0] p_waddr, p_raddr;
    logic [NB-1:0]  p_wdata, p_rdata;

    // effective limit, saturated to the store depth
    logic [TW-1:0] limit_ext, top_ext;
    logic [NB-1:0] top;
    assign limit_ext = TW'(limit);
    assign top_ext   = (limit_ext > TW'(MAX_N - 1)) ? TW'(MAX_N - 1) : limit_ext;
    assign top       = top_ext[NB-1:0];

    // entry read fields
    logic [COUNT_W-1:0] r_b, r_d;
    logic [EXP_W-1:0]   r_e;
    logic               r_mark;
    logic [NB-1:0]      r_spf;
    assign r_b    = e_rdata[B_LO +: COUNT_W];
    assign r_d    = e_rdata[D_LO +: COUNT_W];
    assign r_e    = e_rdata[E_LO +: EXP_W];
    assign r_mark = e_rdata[M_BIT];
    assign r_spf  = e_rdata[S_LO +: NB];

    // multipliers for p*i and the divisor count updates
    logic [2*NB-1:0] prod;
    logic [13:0]     dmul;
    logic [8:0]      d2;
    logic [COUNT_W-1:0] dmul_sat, d2_sat;
    assign prod     = {{NB{1'b0}}, p_rdata} * {{NB{1'b0}}, i_reg[NB-1:0]};
    assign dmul     = {6'd0, b_i_reg} * {8'd0, ({1'b0, e_i_reg} + 6'd2)};
    assign dmul_sat = (dmul > 14'd255) ? D_SAT : dmul[COUNT_W-1:0];
    assign d2       = {d_i_reg, 1'b0};
    assign d2_sat   = d2[8] ? D_SAT : d2[COUNT_W-1:0];

    logic [NB:0] i_inc;
    assign i_inc = i_reg + (NB+1)'(1);

    // query result
    logic in_rng;
    assign in_rng = TW'(k_reg) <= top_ext;

    dcls_ram #(.WIDTH(EW), .DEPTH(MAX_N)) u_entry_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    dcls_ram #(.WIDTH(NB), .DEPTH(PRIME_SLOTS)) u_prime_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            built_reg <= 1'b0;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            built_reg <= built_next;
            pc_reg    <= pc_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        cnt_reg <= cnt_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        d_i_reg <= d_i_next;
        b_i_reg <= b_i_next;
        e_i_reg <= e_i_next;
        s_i_reg <= s_i_next;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        built_next = rebuild ? 1'b0 : built_reg;
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        pc_next    = pc_reg;
        d_i_next   = d_i_reg;
        b_i_next   = b_i_reg;
        e_i_next   = e_i_reg;
        s_i_next   = s_i_reg;
        e_we       = 1'b0;
        e_waddr    = cnt_reg;
        e_wdata    = {{NB{1'b0}}, 1'b0, {EXP_W{1'b0}}, D_ONE, D_ONE};
        e_raddr    = NB'(k_reg);
        p_we       = 1'b0;
        p_waddr    = pc_reg[PAW-1:0];
        p_wdata    = i_reg[NB-1:0];
        p_raddr    = j_reg[PAW-1:0];
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        res.count    = in_rng ? r_d : '0;
        res.exponent = in_rng ? r_e : '0;
        res.is_prime = in_rng && (k_reg >= 16'd2) && !r_mark;
        res.in_range = in_rng;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    k_next   = query;
                    cnt_next = '0;
                    pc_next  = built_reg ? pc_reg : '0;
                    state_next = built_reg ? S_Q_RD : S_CLEAR;
                end
            end
            // clear entries 0..top, leaving d = 1 and e = 0
            S_CLEAR:
            begin
                e_we     = 1'b1;
                cnt_next = cnt_reg + NB'(1);
                if (cnt_reg == top)
                begin
                    i_next = (NB+1)'(2);
                    if (top < NB'(2))
                    begin
                        built_next = 1'b1;
                        state_next = S_Q_RD;
                    end
                    else
                    begin
                        state_next = S_I_RD;
                    end
                end
            end
            S_I_RD:
            begin
                e_raddr    = i_reg[NB-1:0];
                state_next = S_I_CHK;
            end
            // new prime or hold the stored entry of i
            S_I_CHK:
            begin
                j_next = '0;
                if (!r_mark)
                begin
                    d_i_next = D_PRIME;
                    b_i_next = D_ONE;
                    e_i_next = E_ONE;
                    s_i_next = i_reg[NB-1:0];
                    e_we     = 1'b1;
                    e_waddr  = i_reg[NB-1:0];
                    e_wdata  = {i_reg[NB-1:0], 1'b0, E_ONE, D_PRIME, D_ONE};
                    if (pc_reg < PCW'(PRIME_SLOTS))
                    begin
                        p_we    = 1'b1;
                        pc_next = pc_reg + PCW'(1);
                    end
                end
                else
                begin
                    d_i_next = r_d;
                    b_i_next = r_b;
                    e_i_next = r_e;
                    s_i_next = r_spf;
                end
                state_next = S_J_RD;
            end
            S_J_RD:
            begin
                if (j_reg >= pc_reg)
                begin
                    i_next = i_inc;
                    if (i_inc > {1'b0, top})
                    begin
                        built_next = 1'b1;
                        state_next = S_Q_RD;
                    end
                    else
                    begin
                        state_next = S_I_RD;
                    end
                end
                else
                begin
                    state_next = S_J_CHK;
                end
            end
            // mark p*i; stop at the smallest prime factor of i or once p*i exceeds top
            S_J_CHK:
            begin
                e_waddr = prod[NB-1:0];
                if (prod > {{NB{1'b0}}, top} || p_rdata == s_i_reg)
                begin
                    if (prod <= {{NB{1'b0}}, top})
                    begin
                        e_we    = 1'b1;
                        e_wdata = {p_rdata, 1'b1, e_i_reg + E_ONE, dmul_sat, b_i_reg};
                    end
                    i_next = i_inc;
                    if (i_inc > {1'b0, top})
                    begin
                        built_next = 1'b1;
                        state_next = S_Q_RD;
                    end
                    else
                    begin
                        state_next = S_I_RD;
                    end
                end
                else
                begin
                    e_we       = 1'b1;
                    e_wdata    = {p_rdata, 1'b1, E_ONE, d2_sat, d_i_reg};
                    j_next     = j_reg + PCW'(1);
                    state_next = S_J_RD;
                end
            end
            S_Q_RD:
            begin
                state_next = S_Q_RES;
            end
            S_Q_RES:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ hdl/dcls_checker.sv @@
`default_nettype none
module dcls_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // out of range results are all zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[14] |-> m_tdata[13:0] == 14'd0)
        else $error("out of range result not zero");

    // a prime has two divisors and exponent one
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[13] |-> m_tdata[14] && m_tdata[7:0] == 8'd2
            && m_tdata[12:8] == 5'd1)
        else $error("prime result inconsistent");

    // an in range number has at least one divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[14] |-> m_tdata[7:0] != 8'd0)
        else $error("in range result with zero divisors");

endmodule

bind divisor_count_linear_sieve dcls_checker u_dcls_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    import dcls_pkg::*;

    // one row of the directed table
    typedef struct {
        logic [15:0] query;
        bit          typed;
        dcls_res_t   res;
    } query_row_t;

    logic        clk;
    logic        rst_n;
    logic [15:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor state and expected result items
    logic [15:0] limit_q;
    dcls_res_t   pending_res[$];
    int          mismatches;
    int          results_seen;
    int          queries_sent;
    int          idle_cycles = 0;
    int          limits_tried;
    bit          calm_mode;

    divisor_count_linear_sieve u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // divisor count, smallest prime exponent and primality of k by factoring
    function automatic dcls_res_t divisor_info(logic [15:0] k, logic [15:0] lim);
        dcls_res_t r;
        int        n;
        int        p;
        int        e;
        int        d;
        bit        first;
        r     = '0;
        n     = k;
        d     = 1;
        first = 1'b1;
        if (k > lim)
            return r;
        r.in_range = 1'b1;
        if (k < 2)
        begin
            r.count = D_ONE;
            return r;
        end
        for (p = 2; p * p <= n; p++)
        begin
            if (n % p == 0)
            begin
                e = 0;
                while (n % p == 0)
                begin
                    n = n / p;
                    e++;
                end
                d = d * (e + 1);
                if (first)
                    r.exponent = e[EXP_W-1:0];
                first = 1'b0;
            end
        end
        if (n > 1)
        begin
            d = d * 2;
            if (first)
                r.exponent = E_ONE;
        end
        r.is_prime = (n == k);
        r.count    = (d > 255) ? D_SAT : d[COUNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0d, got %0d", what, exp_v, act_v);
    endtask

    // apb write then read back
    task automatic limit_write(logic [15:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {IDX_LIMIT, 2'b00};
        pwdata  <= {16'h0, value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        limit_q = value;
        limits_tried++;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[15:0] !== value)
            report_mismatch("limit readback", 32'(value), 32'(prdata[15:0]));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // present one query item and record its expected result at acceptance
    task automatic send_query(logic [15:0] k);
        int gap;
        gap = calm_mode ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= k;
        do @(posedge clk); while (!s_tready);
        pending_res.push_back(divisor_info(k, limit_q));
        queries_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // random queries: mostly in range, some near the limit, some anywhere
    task automatic random_phase(int count);
        int          i;
        int          pick;
        logic [15:0] k;
        for (i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
                calm_mode = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 6)
                k = 16'($urandom_range(0, limit_q));
            else if (pick < 8)
                k = 16'($urandom);
            else
                k = 16'(limit_q + $urandom_range(0, 2) - 1);
            send_query(k);
            // hold off until everything in flight has come back
            if (i % 97 == 50)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                while (pending_res.size() != 0)
                    @(posedge clk);
            end
        end
        calm_mode = 1'b0;
    endtask

    // receiver back-pressure
    initial
    begin
        int n;
        m_tready = 1'b0;
        forever
        begin
            n = calm_mode ? 0 : $urandom_range(0, 3);
            @(negedge clk);
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    // result checker
    always @(posedge clk)
    begin
        dcls_res_t got;
        dcls_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[$bits(dcls_res_t)-1:0];
            results_seen++;
            if (pending_res.size() == 0)
                report_mismatch("unexpected result item", 0, 32'(m_tdata));
            else
            begin
                want = pending_res.pop_front();
                if (got.count !== want.count)
                    report_mismatch("divisor_count", 32'(want.count), 32'(got.count));
                if (got.exponent !== want.exponent)
                    report_mismatch("min_prime_exponent", 32'(want.exponent),
                                    32'(got.exponent));
                if (got.is_prime !== want.is_prime)
                    report_mismatch("is_prime", 32'(want.is_prime), 32'(got.is_prime));
                if (got.in_range !== want.in_range)
                    report_mismatch("in_range", 32'(want.in_range), 32'(got.in_range));
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        query_row_t rows[$];
        int         r;
        int         lims[6];
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        mismatches   = 0;
        results_seen = 0;
        queries_sent = 0;
        limits_tried = 0;
        calm_mode    = 1'b0;
        limit_q      = LIMIT_RESET;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset value of the limit register
        @(negedge clk);
        psel    <= 1'b1;
        paddr   <= {IDX_LIMIT, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[15:0] !== LIMIT_RESET)
            report_mismatch("limit after reset", 32'(LIMIT_RESET), 32'(prdata[15:0]));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;

        // directed queries on the full range after reset
        rows.push_back('{16'd0,     1'b1, '{1'b1, 1'b0, 5'd0,  8'd1}});
        rows.push_back('{16'd1,     1'b1, '{1'b1, 1'b0, 5'd0,  8'd1}});
        rows.push_back('{16'd2,     1'b1, '{1'b1, 1'b1, 5'd1,  8'd2}});
        rows.push_back('{16'd4,     1'b1, '{1'b1, 1'b0, 5'd2,  8'd3}});
        rows.push_back('{16'd32768, 1'b1, '{1'b1, 1'b0, 5'd15, 8'd16}});
        rows.push_back('{16'd65535, 1'b0, '0});
        rows.push_back('{16'd65521, 1'b0, '0});
        rows.push_back('{16'd55440, 1'b0, '0});
        rows.push_back('{16'd45360, 1'b0, '0});
        rows.push_back('{16'd65534, 1'b0, '0});
        rows.push_back('{16'h5555,  1'b0, '0});
        rows.push_back('{16'hAAAA,  1'b0, '0});
        for (r = 0; r < rows.size(); r++)
        begin
            send_query(rows[r].query);
            if (rows[r].typed && pending_res[$] !== rows[r].res)
                report_mismatch("directed row prediction", 32'(rows[r].res),
                                32'(pending_res[$]));
        end
        drain_results();

        // limit of zero: only k = 0 is in range
        limit_write(16'd0);
        send_query(16'd0);
        send_query(16'd1);
        send_query(16'hFFFF);
        drain_results();

        // limit of one
        limit_write(16'd1);
        send_query(16'd1);
        send_query(16'd2);
        drain_results();

        // same value again still rebuilds
        limit_write(16'd1);
        send_query(16'd0);
        send_query(16'd1);
        drain_results();

        // random phases over several limits, the full range last
        lims = '{2, 97, 1000, 4096, 0, 65535};
        lims[4] = $urandom_range(3, 20000);
        for (r = 0; r < 6; r++)
        begin
            limit_write(16'(lims[r]));
            random_phase(250);
            drain_results();
        end

        repeat (20) @(posedge clk);
        $display("ran %0d queries over %0d limit settings, %0d result items checked",
                 queries_sent, limits_tried + 1, results_seen);
        $display("limits 0, 1 and 65535 included, with random stalls on both streams");
        if (mismatches == 0 && pending_res.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/dcls_pkg.sv
hdl/dcls_ram.sv
hdl/dcls_core.sv
hdl/divisor_count_linear_sieve.sv
hdl/dcls_checker.sv
dv/tb_top.sv
